[rtl/rbi_pkg.sv]
// ----------------------------------------------------------------------------
// rbi_pkg
// Shared types and constants for the ray versus box intersection pipeline.
// ----------------------------------------------------------------------------
package rbi_pkg;

	// Q16.16 coordinate
	typedef logic signed [31:0] fix_t;

	localparam int AXES      = 3;
	localparam int FRAC_W    = 16;
	localparam int MAG_W     = 33;                    // |plane - origin|
	localparam int NUM_W     = 52;                    // padded dividend width
	localparam int DEN_W     = 32;                    // |dir|
	localparam int BITS_STG  = 4;                     // quotient bits per stage
	localparam int DIV_STG   = NUM_W / BITS_STG;      // divider depth
	localparam int HIT_W     = 49;                    // full-precision hit coord

	localparam logic signed [31:0] NEG_ONE_Q = -32'sd65536;
	localparam logic signed [31:0] FIX_MAX   = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] FIX_MIN   = 32'sh8000_0000;

	// register indexes of the configuration port
	localparam logic [2:0] REG_MIN_X = 3'd0;
	localparam logic [2:0] REG_MIN_Y = 3'd1;
	localparam logic [2:0] REG_MIN_Z = 3'd2;
	localparam logic [2:0] REG_MAX_X = 3'd3;
	localparam logic [2:0] REG_MAX_Y = 3'd4;
	localparam logic [2:0] REG_MAX_Z = 3'd5;

	// per-ray side data carried alongside the dividers
	typedef struct packed {
		logic [2:0][31:0] org;
		logic [2:0][31:0] dir;
		logic [2:0][31:0] plane;
		logic [2:0]       use_div;  // axis has a candidate plane and dir != 0
		logic [2:0]       neg;      // quotient sign is negative
		logic             org_in;
	} ray_t;

endpackage

[rtl/ray_box_intersect.sv]
// Pipeline registers in order: classify, the 13-stage divider, t/saturate, select,
// multiply, and the range check into the output register.
// Throughput: one ray per cycle while the result is taken.
// Whole pipeline stalls together while the result is not taken.
// Reset: arst_n clears valid bits and the box corners to zero.
// ----------------------------------------------------------------------------
// ray_box_intersect
// Ray versus axis-aligned box test by the candidate-plane method, Q16.16.
// ----------------------------------------------------------------------------
module ray_box_intersect import rbi_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	// configuration
	input  logic         cfg_we,
	input  logic [2:0]   cfg_idx,
	input  logic [31:0]  cfg_data,
	// ray requests
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [191:0] s_tdata,  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
	// results
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata   // hit_flag, origin_inside, hit_x, hit_y, hit_z, pad
);

	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// box corner registers
	logic [2:0][31:0] box_lo_q, box_hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_lo_q <= '0;
			box_hi_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_MIN_X: box_lo_q[0] <= cfg_data;
				REG_MIN_Y: box_lo_q[1] <= cfg_data;
				REG_MIN_Z: box_lo_q[2] <= cfg_data;
				REG_MAX_X: box_hi_q[0] <= cfg_data;
				REG_MAX_Y: box_hi_q[1] <= cfg_data;
				REG_MAX_Z: box_hi_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1: classify axes, form dividend and divisor magnitudes
	ray_t             ray_c;
	logic [2:0][NUM_W-1:0] num_c;
	logic [2:0][DEN_W-1:0] den_c;

	always_comb begin
		logic below, above;
		logic signed [33:0] diff;
		logic [33:0] mag;
		ray_c.org_in = 1'b1;
		for (int i = 0; i < AXES; i++) begin
			ray_c.org[i] = s_tdata[32*i +: 32];
			ray_c.dir[i] = s_tdata[96 + 32*i +: 32];
			below = $signed(ray_c.org[i]) < $signed(box_lo_q[i]);
			above = $signed(ray_c.org[i]) > $signed(box_hi_q[i]);
			ray_c.plane[i] = below ? box_lo_q[i] : (above ? box_hi_q[i] : '0);
			ray_c.use_div[i] = (below || above) && (ray_c.dir[i] != '0);
			if (below || above)
				ray_c.org_in = 1'b0;
			diff = $signed({{2{ray_c.plane[i][31]}}, ray_c.plane[i]})
				- $signed({{2{ray_c.org[i][31]}}, ray_c.org[i]});
			mag = diff[33] ? -diff : diff;
			ray_c.neg[i] = diff[33] ^ ray_c.dir[i][31];
			num_c[i] = {{(NUM_W-MAG_W-FRAC_W){1'b0}}, mag[MAG_W-1:0], {FRAC_W{1'b0}}};
			den_c[i] = ray_c.dir[i][31] ? -ray_c.dir[i] : ray_c.dir[i];
		end
	end

	ray_t                  ray_s1;
	logic [2:0][NUM_W-1:0] num_s1;
	logic [2:0][DEN_W-1:0] den_s1;
	logic                  vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (en)
			vld_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s1 <= ray_c;
			num_s1 <= num_c;
			den_s1 <= den_c;
		end
	end

	// dividers, one per axis
	logic [2:0][NUM_W-1:0] quo;
	logic [2:0]            rem_nz;

	for (genvar a = 0; a < AXES; a++) begin : g_div
		rbi_div u_div (
			.clk    (clk),
			.en     (en),
			.num    (num_s1[a]),
			.den    (den_s1[a]),
			.quo    (quo[a]),
			.rem_nz (rem_nz[a])
		);
	end

	// side data delay line, matched to the divider depth
	ray_t             ray_sd [DIV_STG];
	logic [DIV_STG-1:0] vld_sd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_sd <= '0;
		else if (en)
			vld_sd <= {vld_sd[DIV_STG-2:0], vld_s1};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ray_sd[0] <= ray_s1;
			for (int k = 1; k < DIV_STG; k++)
				ray_sd[k] <= ray_sd[k-1];
		end
	end

	// stage 2: signed floor quotient with saturation
	logic [2:0][31:0] t_c;

	always_comb begin
		logic [NUM_W:0] m;
		for (int i = 0; i < AXES; i++) begin
			m = {1'b0, quo[i]} + {{NUM_W{1'b0}}, rem_nz[i]};
			if (!ray_sd[DIV_STG-1].use_div[i])
				t_c[i] = NEG_ONE_Q;
			else if (!ray_sd[DIV_STG-1].neg[i])
				t_c[i] = (quo[i] > {{(NUM_W-31){1'b0}}, {31{1'b1}}}) ? FIX_MAX
					: quo[i][31:0];
			else
				t_c[i] = (m > {{(NUM_W-31){1'b0}}, 1'b1, 31'd0}) ? FIX_MIN
					: -m[31:0];
		end
	end

	ray_t             ray_s2;
	logic [2:0][31:0] t_s2;
	logic             vld_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else if (en)
			vld_s2 <= vld_sd[DIV_STG-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s2 <= ray_sd[DIV_STG-1];
			t_s2   <= t_c;
		end
	end

	// stage 3: largest t, first axis wins a tie
	logic [1:0]  best_c;
	logic [31:0] tbest_c;

	always_comb begin
		best_c  = 2'd0;
		tbest_c = t_s2[0];
		if ($signed(tbest_c) < $signed(t_s2[1])) begin
			best_c  = 2'd1;
			tbest_c = t_s2[1];
		end
		if ($signed(tbest_c) < $signed(t_s2[2])) begin
			best_c  = 2'd2;
			tbest_c = t_s2[2];
		end
	end

	ray_t        ray_s3;
	logic [1:0]  best_s3;
	logic [31:0] tbest_s3;
	logic        vld_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s3 <= 1'b0;
		else if (en)
			vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s3   <= ray_s2;
			best_s3  <= best_c;
			tbest_s3 <= tbest_c;
		end
	end

	// stage 4: t * dir per axis
	ray_t             ray_s4;
	logic [1:0]       best_s4;
	logic             tneg_s4;
	logic [2:0][63:0] prod_s4;
	logic             vld_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s4 <= 1'b0;
		else if (en)
			vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s4  <= ray_s3;
			best_s4 <= best_s3;
			tneg_s4 <= tbest_s3[31];
			for (int i = 0; i < AXES; i++)
				prod_s4[i] <= $signed(tbest_s3) * $signed(ray_s3.dir[i]);
		end
	end

	// stage 5: hit coordinates, range check and result
	logic [103:0] res_c;

	always_comb begin
		logic signed [HIT_W-1:0] hit, lo, hi;
		logic ok;
		logic [2:0][31:0] pt;
		ok = 1'b1;
		for (int i = 0; i < AXES; i++) begin
			hit = $signed({{(HIT_W-32){ray_s4.org[i][31]}}, ray_s4.org[i]})
				+ $signed({prod_s4[i][63], prod_s4[i][63:16]});
			lo  = $signed({{(HIT_W-32){box_lo_q[i][31]}}, box_lo_q[i]});
			hi  = $signed({{(HIT_W-32){box_hi_q[i][31]}}, box_hi_q[i]});
			if (best_s4 == 2'(i)) begin
				pt[i] = ray_s4.plane[i];
			end else begin
				pt[i] = hit[31:0];
				if (hit < lo || hit > hi)
					ok = 1'b0;
			end
		end
		res_c = '0;
		if (ray_s4.org_in) begin
			res_c[0]     = 1'b1;
			res_c[1]     = 1'b1;
			res_c[97:2]  = {ray_s4.org[2], ray_s4.org[1], ray_s4.org[0]};
		end else if (!tneg_s4 && ok) begin
			res_c[0]     = 1'b1;
			res_c[97:2]  = {pt[2], pt[1], pt[0]};
		end
	end

	logic [103:0] res_q;
	logic         vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= 1'b0;
		else if (en)
			vld_q <= vld_s4;
	end

	always_ff @(posedge clk) begin
		if (en)
			res_q <= res_c;
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = res_q;

`ifndef SYNTH
	// an inside origin is always a hit
	a_inside_hits: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1] |-> m_tdata[0])
		else $error("origin_inside without hit_flag");

	// a miss carries a zero hit point
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> (m_tdata[97:2] == '0))
		else $error("miss with non-zero hit point");

	// a stalled result stays put
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");
`endif

endmodule

[rtl/rbi_div.sv]
// ----------------------------------------------------------------------------
// rbi_div
// Pipelined unsigned restoring divider, BITS_STG quotient bits per stage.
// ----------------------------------------------------------------------------
module rbi_div import rbi_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo,
	output logic             rem_nz
);

	logic [DEN_W-1:0] rem_s [DIV_STG];
	logic [NUM_W-1:0] num_s [DIV_STG];
	logic [NUM_W-1:0] quo_s [DIV_STG];
	logic [DEN_W-1:0] den_s [DIV_STG];

	for (genvar k = 0; k < DIV_STG; k++) begin : g_stg
		logic [DEN_W-1:0] rem_i;
		logic [NUM_W-1:0] num_i;
		logic [NUM_W-1:0] quo_i;
		logic [DEN_W-1:0] den_i;
		logic [DEN_W-1:0] rem_o;
		logic [NUM_W-1:0] num_o;
		logic [NUM_W-1:0] quo_o;

		if (k == 0) begin : g_first
			assign rem_i = '0;
			assign num_i = num;
			assign quo_i = '0;
			assign den_i = den;
		end else begin : g_next
			assign rem_i = rem_s[k-1];
			assign num_i = num_s[k-1];
			assign quo_i = quo_s[k-1];
			assign den_i = den_s[k-1];
		end

		// BITS_STG shift-and-subtract steps
		always_comb begin
			logic [DEN_W:0] trial;
			rem_o = rem_i;
			num_o = num_i;
			quo_o = quo_i;
			for (int b = 0; b < BITS_STG; b++) begin
				trial = {rem_o, num_o[NUM_W-1]};
				num_o = {num_o[NUM_W-2:0], 1'b0};
				if (trial >= {1'b0, den_i}) begin
					trial = trial - {1'b0, den_i};
					quo_o = {quo_o[NUM_W-2:0], 1'b1};
				end else begin
					quo_o = {quo_o[NUM_W-2:0], 1'b0};
				end
				rem_o = trial[DEN_W-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= rem_o;
				num_s[k] <= num_o;
				quo_s[k] <= quo_o;
				den_s[k] <= den_i;
			end
		end
	end

	assign quo    = quo_s[DIV_STG-1];
	assign rem_nz = |rem_s[DIV_STG-1];

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for ray_box_intersect: random and directed rays against
// several box settings, predicted in fixed point and checked in order.
// ----------------------------------------------------------------------------
module tb;
	import rbi_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// expected hit result
	typedef struct {
		logic        hit;
		logic        org_in;
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] pz;
	} hit_res_t;

	// box model and queue of pending hit results
	class hit_board;
		longint lo[3];
		longint hi[3];
		hit_res_t pending[$];
		int errors;

		function void set_reg(logic [2:0] idx, logic [31:0] v);
			if (idx < 3) lo[idx] = longint'(signed'(v));
			else if (idx < 6) hi[idx - 3] = longint'(signed'(v));
		endfunction

		function longint fdiv(longint n, longint d);
			longint q;
			longint r;
			q = n / d;
			r = n % d;
			if (r != 0 && ((r < 0) != (d < 0))) q = q - 1;
			return q;
		endfunction

		// note an accepted ray and work out its result
		function void note_ray(logic [191:0] d);
			longint o[3], dr[3], pl[3], t[3], h[3];
			bit used[3];
			bit ins;
			bit ok;
			int best;
			hit_res_t r;
			ins = 1;
			for (int i = 0; i < 3; i++) begin
				o[i] = longint'(signed'(d[32*i +: 32]));
				dr[i] = longint'(signed'(d[32*(i+3) +: 32]));
				used[i] = 0;
				pl[i] = 0;
				if (o[i] < lo[i]) begin
					pl[i] = lo[i]; used[i] = 1; ins = 0;
				end else if (o[i] > hi[i]) begin
					pl[i] = hi[i]; used[i] = 1; ins = 0;
				end
			end
			r = '{0, 0, 0, 0, 0};
			if (ins) begin
				r = '{1, 1, o[0][31:0], o[1][31:0], o[2][31:0]};
			end else begin
				for (int i = 0; i < 3; i++) begin
					if (used[i] && dr[i] != 0) begin
						t[i] = fdiv((pl[i] - o[i]) * 65536, dr[i]);
						if (t[i] > 64'sd2147483647) t[i] = 64'sd2147483647;
						if (t[i] < -64'sd2147483648) t[i] = -64'sd2147483648;
					end else begin
						t[i] = -65536;
					end
				end
				best = 0;
				for (int i = 1; i < 3; i++) if (t[best] < t[i]) best = i;
				if (t[best] >= 0) begin
					ok = 1;
					for (int i = 0; i < 3; i++) begin
						if (i != best) begin
							h[i] = o[i] + fdiv(t[best] * dr[i], 65536);
							if (h[i] < lo[i] || h[i] > hi[i]) ok = 0;
						end else begin
							h[i] = pl[i];
						end
					end
					if (ok) r = '{1, 0, h[0][31:0], h[1][31:0], h[2][31:0]};
				end
			end
			pending.push_back(r);
		endfunction

		// check one accepted result against the oldest expectation
		function void check_result(logic [103:0] m);
			hit_res_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, m);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (m[0] !== e.hit) begin
				$display("%0t: hit_flag exp %0b got %0b", $time, e.hit, m[0]); errors++;
			end
			if (m[1] !== e.org_in) begin
				$display("%0t: origin_inside exp %0b got %0b", $time, e.org_in, m[1]);
				errors++;
			end
			if (m[33:2] !== e.px) begin
				$display("%0t: hit_x exp %h got %h", $time, e.px, m[33:2]); errors++;
			end
			if (m[65:34] !== e.py) begin
				$display("%0t: hit_y exp %h got %h", $time, e.py, m[65:34]); errors++;
			end
			if (m[97:66] !== e.pz) begin
				$display("%0t: hit_z exp %h got %h", $time, e.pz, m[97:66]); errors++;
			end
		endfunction
	endclass

	logic         clk = 0;
	logic         arst_n = 0;
	logic         cfg_we = 0;
	logic [2:0]   cfg_idx = '0;
	logic [31:0]  cfg_data = '0;
	logic         s_tvalid = 0;
	logic         s_tready;
	logic [191:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 0;
	logic [103:0] m_tdata;

	hit_board board;
	bit quiet = 0;      // no idling in the final stretch
	int stall_cnt = 0;
	int idle_cycles = 0;
	int box_id;
	logic [31:0] box_lo_r[3];
	logic [31:0] box_hi_r[3];

	ray_box_intersect dut (.*);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// result side: random stalls, checking
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) board.check_result(m_tdata);
			if (stall_cnt > 0) begin
				stall_cnt <= stall_cnt - 1;
				m_tready <= 0;
			end else if (!quiet && $urandom_range(0, 15) == 0) begin
				stall_cnt <= $urandom_range(1, 18) - 1;
				m_tready <= 0;
			end else begin
				m_tready <= 1;
			end
		end
	end

	// watchdog on cycles with no accepted request or result
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 2000) begin
			$display("** ray_box_intersect: FAILED **");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] v);
		@(posedge clk);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_data <= v;
		board.set_reg(idx, v);
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic send_ray(logic [191:0] d);
		if (!quiet && $urandom_range(0, 11) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
		board.note_ray(d);
	endtask

	// drop the request at the edge of the last acceptance, then drain
	task automatic wait_drain();
		s_tvalid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [31:0] rnd_coord();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return FIX_MAX;
			2: return FIX_MIN;
			3: return 32'($signed($urandom_range(0, 20)) - 10) <<< 16;
			default: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
		endcase
	endfunction

	// coordinate near a box axis span
	function automatic logic [31:0] near_box(int a);
		longint lo_v, hi_v, v;
		lo_v = longint'(signed'(box_lo_r[a]));
		hi_v = longint'(signed'(box_hi_r[a]));
		case ($urandom_range(0, 4))
			0: v = lo_v;
			1: v = hi_v;
			2: v = lo_v - $urandom_range(0, 32'h0004_0000);
			3: v = hi_v + $urandom_range(0, 32'h0004_0000);
			default: v = lo_v + $urandom_range(0, 32'h0001_0000);
		endcase
		return v[31:0];
	endfunction

	// ray aimed at a point on or near the box
	function automatic logic [191:0] aimed_ray();
		logic [31:0] tgt[3], org[3];
		logic [191:0] d;
		int k;
		for (int a = 0; a < 3; a++) tgt[a] = near_box(a);
		k = $urandom_range(1, 4);
		for (int a = 0; a < 3; a++) begin
			org[a] = tgt[a] + ($urandom_range(0, 32'h0001_0000) - 32'h0000_8000) * k;
			d[32*a +: 32] = org[a];
			d[32*(a+3) +: 32] = tgt[a] - org[a];
		end
		return d;
	endfunction

	function automatic logic [191:0] rnd_ray();
		logic [191:0] d;
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 6) return aimed_ray();
		for (int a = 0; a < 3; a++) begin
			d[32*a +: 32] = (sel < 8) ? near_box(a) : rnd_coord();
			d[32*(a+3) +: 32] = ($urandom_range(0, 7) == 0) ? 32'd0 : rnd_coord();
		end
		return d;
	endfunction

	task automatic load_box(logic [31:0] l0, logic [31:0] l1, logic [31:0] l2,
			logic [31:0] h0, logic [31:0] h1, logic [31:0] h2);
		box_lo_r = '{l0, l1, l2};
		box_hi_r = '{h0, h1, h2};
		write_reg(REG_MIN_X, l0);
		write_reg(REG_MIN_Y, l1);
		write_reg(REG_MIN_Z, l2);
		write_reg(REG_MAX_X, h0);
		write_reg(REG_MAX_Y, h1);
		write_reg(REG_MAX_Z, h2);
	endtask

	// stimulus
	initial begin
		logic [31:0] one;
		board = new();
		box_lo_r = '{0, 0, 0};
		box_hi_r = '{0, 0, 0};
		one = 32'h0001_0000;
		repeat (9) @(posedge clk);
		arst_n <= 1;

		// directed: unit box, inside, miss, behind, zero dir, extremes
		load_box(-one, -one, -one, one, one, one);
		send_ray({96'd0, 32'd0, 32'd0, 32'd0});
		send_ray({32'd0, 32'd0, one, 32'd0, 32'd0, -(3 * one)});
		send_ray({32'd0, 32'd0, -one, 32'd0, 32'd0, -(3 * one)});
		send_ray({32'd0, one, one, 32'd0, 32'd0, -(3 * one)});
		send_ray({32'd0, 32'd0, 32'd0, 32'd0, 32'd0, -(3 * one)});
		send_ray({-one, -one, -one, 3 * one, 3 * one, 3 * one});
		send_ray({32'd1, 32'd0, 32'd0, FIX_MIN, 32'd0, 32'd0});
		send_ray({FIX_MIN, FIX_MIN, FIX_MIN, FIX_MAX, FIX_MAX, FIX_MAX});
		send_ray({FIX_MAX, FIX_MAX, FIX_MAX, FIX_MIN, FIX_MIN, FIX_MIN});
		send_ray({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
		send_ray({32'd0, 32'd0, 32'd1, 32'd0, 32'd0, -(3 * one)});
		send_ray({one, one, one, one, one, one});
		wait_drain();

		// extreme and inverted boxes
		load_box(FIX_MIN, FIX_MIN, FIX_MIN, FIX_MAX, FIX_MAX, FIX_MAX);
		send_ray({FIX_MIN, FIX_MAX, 32'd0, FIX_MAX, FIX_MIN, 32'd5});
		send_ray({96'd0, 96'd0});
		wait_drain();
		load_box(one, -one, -one, -one, one, one);
		send_ray({32'd0, 32'd0, one, 32'd0, 32'd0, -(3 * one)});
		send_ray({32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0});
		send_ray({32'd0, 32'd0, -(2 * one), 32'd0, 32'd0, 2 * one});
		wait_drain();

		// random phases across several boxes
		for (box_id = 0; box_id < 8; box_id++) begin
			logic [31:0] a, b;
			logic [31:0] lo_v[3], hi_v[3];
			for (int ax = 0; ax < 3; ax++) begin
				a = (box_id == 7) ? $urandom() :
					($urandom_range(0, 32'h000A_0000) - 32'h0005_0000);
				b = a + ((box_id == 6) ? -$urandom_range(0, 32'h0002_0000) :
					$urandom_range(0, 32'h0004_0000));
				lo_v[ax] = a;
				hi_v[ax] = b;
			end
			load_box(lo_v[0], lo_v[1], lo_v[2], hi_v[0], hi_v[1], hi_v[2]);
			if (box_id == 7) quiet = 1;
			repeat (130) send_ray(rnd_ray());
			wait_drain();
		end

		if (board.errors == 0 && board.pending.size() == 0)
			$display("** ray_box_intersect: PASSED **");
		else
			$display("** ray_box_intersect: FAILED **");
		$finish;
	end
endmodule
